[rtl/core/mtg_pkg.sv]
package mtg_pkg;

    localparam int MaxVerts = 1024;
    localparam int IdxW     = 10;
    localparam int CntW     = 11;

    localparam logic [1:0] OP_ADD_VERTEX = 2'd0;
    localparam logic [1:0] OP_ADD_TRI    = 2'd1;
    localparam logic [1:0] OP_READ       = 2'd2;
    localparam logic [1:0] OP_CLEAR      = 2'd3;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_DEGENERATE = 3'd1;
    localparam logic [2:0] ST_RANGE      = 3'd2;
    localparam logic [2:0] ST_FULL       = 3'd3;
    localparam logic [2:0] ST_ZERO       = 3'd4;

    typedef struct packed {
        logic [1:0]         operation;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
        logic signed [15:0] tex_u;
        logic signed [15:0] tex_v;
        logic signed [15:0] nrm_x;
        logic signed [15:0] nrm_y;
        logic signed [15:0] nrm_z;
        logic [9:0]         idx0;
        logic [9:0]         idx1;
        logic [9:0]         idx2;
    } mtg_in_t;

    typedef struct packed {
        logic signed [15:0] tan_x;
        logic signed [15:0] tan_y;
        logic signed [15:0] tan_z;
        logic [2:0]         status;
    } mtg_out_t;

    // Command passed from the front end to the back end, with the vertex
    // data so that the stores are written in command order.
    typedef struct packed {
        logic [1:0]         op;
        logic [2:0]         status;
        logic [IdxW-1:0]    ia;
        logic [IdxW-1:0]    ib;
        logic [IdxW-1:0]    ic;
        logic [47:0]        pos;
        logic [31:0]        tex;
        logic [47:0]        nrm;
    } mtg_cmd_t;

endpackage

[rtl/core/mtg_front.sv]
module mtg_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  mtg_pkg::mtg_in_t s_data,
    output logic             q_valid,
    input  logic             q_ready,
    output mtg_pkg::mtg_cmd_t q_cmd
);
    import mtg_pkg::*;

    logic [CntW-1:0] count_reg, count_next;
    logic            acc;
    logic            in_rng;
    logic            full;

    assign s_ready = q_ready;
    assign acc     = s_valid && s_ready;
    assign full    = (count_reg >= CntW'(MaxVerts));
    assign in_rng  = ({1'b0, s_data.idx0} < count_reg)
                  && ({1'b0, s_data.idx1} < count_reg)
                  && ({1'b0, s_data.idx2} < count_reg);

    // Classify the incoming word and build the back-end command.
    always_comb begin
        q_cmd.op     = s_data.operation;
        q_cmd.ia     = s_data.idx0;
        q_cmd.ib     = s_data.idx1;
        q_cmd.ic     = s_data.idx2;
        q_cmd.pos    = {s_data.pos_x, s_data.pos_y, s_data.pos_z};
        q_cmd.tex    = {s_data.tex_u, s_data.tex_v};
        q_cmd.nrm    = {s_data.nrm_x, s_data.nrm_y, s_data.nrm_z};
        q_cmd.status = ST_OK;
        count_next   = count_reg;
        case (s_data.operation)
            OP_ADD_VERTEX: begin
                if (full) begin
                    q_cmd.status = ST_FULL;
                end else begin
                    q_cmd.ia    = count_reg[IdxW-1:0];
                    count_next  = count_reg + 1'b1;
                end
            end
            OP_ADD_TRI: if (!in_rng) q_cmd.status = ST_RANGE;
            OP_READ: if ({1'b0, s_data.idx0} >= count_reg) q_cmd.status = ST_RANGE;
            default: count_next = '0;
        endcase
    end

    assign q_valid = s_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (acc) begin
            count_reg <= count_next;
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CntW'(MaxVerts)) else $error("vertex count overflow");
    a_full_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        (acc && s_data.operation == OP_ADD_VERTEX && full) |-> q_cmd.status == ST_FULL)
        else $error("full store not flagged");
    a_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (acc && s_data.operation == OP_CLEAR) |=> count_reg == '0)
        else $error("clear missed");
`endif
endmodule

[rtl/core/mtg_queue.sv]
module mtg_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              i_valid,
    output logic              i_ready,
    input  mtg_pkg::mtg_cmd_t i_cmd,
    output logic              o_valid,
    input  logic              o_ready,
    output mtg_pkg::mtg_cmd_t o_cmd
);
    import mtg_pkg::*;

    mtg_cmd_t   mem_reg [2];
    logic [1:0] wp_reg, rp_reg;
    logic [1:0] cnt;

    assign cnt     = wp_reg - rp_reg;
    assign i_ready = (cnt != 2'd2);
    assign o_valid = (cnt != 2'd0);
    assign o_cmd   = mem_reg[rp_reg[0]];

    // Two-entry command queue.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= '0;
            rp_reg <= '0;
        end else begin
            if (i_valid && i_ready) wp_reg <= wp_reg + 1'b1;
            if (o_valid && o_ready) rp_reg <= rp_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (i_valid && i_ready) mem_reg[wp_reg[0]] <= i_cmd;
    end

`ifndef SYNTH
    a_no_over: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt <= 2'd2) else $error("queue overflow");
    a_empty_keep: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt == 2'd0 && !i_valid) |=> cnt == 2'd0) else $error("queue invented entry");
    a_full_keep: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt == 2'd2 && !o_ready) |=> cnt == 2'd2) else $error("queue lost entry");
`endif
endmodule

[rtl/core/mtg_back.sv]
module mtg_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    output logic              q_ready,
    input  mtg_pkg::mtg_cmd_t q_cmd,
    output logic              m_valid,
    input  logic              m_ready,
    output mtg_pkg::mtg_out_t m_data
);
    import mtg_pkg::*;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_RD    = 5'd1;
    localparam logic [4:0] S_LD    = 5'd2;
    localparam logic [4:0] S_DIFF  = 5'd3;
    localparam logic [4:0] S_DET   = 5'd4;
    localparam logic [4:0] S_NUM   = 5'd5;
    localparam logic [4:0] S_DIV   = 5'd6;
    localparam logic [4:0] S_ACC   = 5'd7;
    localparam logic [4:0] S_WR    = 5'd8;
    localparam logic [4:0] S_DOT   = 5'd9;
    localparam logic [4:0] S_SUB   = 5'd10;
    localparam logic [4:0] S_NORM  = 5'd11;
    localparam logic [4:0] S_SQ    = 5'd12;
    localparam logic [4:0] S_SQRT  = 5'd13;
    localparam logic [4:0] S_QDIV  = 5'd14;
    localparam logic [4:0] S_OUT   = 5'd15;
    localparam logic [4:0] S_CLR   = 5'd16;
    localparam logic [4:0] S_DOT2  = 5'd17;

    // Vertex stores and accumulators, one word per vertex.
    logic [47:0] pos_mem [MaxVerts];
    logic [31:0] tex_mem [MaxVerts];
    logic [47:0] nrm_mem [MaxVerts];
    logic [95:0] acc_mem [MaxVerts];

    logic [4:0]  st_reg;
    mtg_cmd_t    cmd_reg;
    logic [1:0]  k_reg;
    logic [IdxW-1:0] ra;
    logic [47:0] pos_q;
    logic [31:0] tex_q;
    logic [47:0] nrm_q;
    logic [95:0] acc_q;
    logic        vtx_we;
    logic        acc_we;
    logic [IdxW-1:0] acc_wa;
    logic [95:0] acc_wd;

    logic signed [15:0] p_reg [3][3];
    logic signed [15:0] t_reg [3][2];
    logic signed [17:0] e1_reg [3], e2_reg [3];
    logic signed [16:0] d1u_reg, d1v_reg, d2u_reg, d2v_reg;
    logic signed [34:0] det_reg;
    logic signed [35:0] num_reg [3];
    logic signed [31:0] tan_reg [3];

    // Shared restoring divider: 56-bit magnitude by 36-bit divisor.
    logic [55:0] dn_reg;
    logic [35:0] dd_reg;
    logic [55:0] dq_reg;
    logic [36:0] dr_reg;
    logic [5:0]  dc_reg;
    logic        dneg_reg;
    logic [37:0] dtrial;

    logic signed [31:0] tv_reg [3];
    logic signed [15:0] nv_reg [3];
    logic signed [49:0] dot_reg;
    logic signed [49:0] prod;
    logic signed [33:0] tw_reg [3];
    logic [33:0] m_reg [3];
    logic [63:0] sum_reg;
    logic [63:0] sum_next;
    logic [63:0] sq_n_reg, sq_r_reg, sq_b_reg;
    logic [31:0] len_reg;
    logic signed [15:0] o_reg [3];
    logic        ov_reg;
    mtg_out_t    od_reg;

    logic [33:0] mx;
    logic        busy_ok;

    assign q_ready = (st_reg == S_IDLE) && !ov_reg;
    assign m_valid = ov_reg;
    assign m_data  = od_reg;
    assign mx = (m_reg[0] > m_reg[1]) ? ((m_reg[0] > m_reg[2]) ? m_reg[0] : m_reg[2])
                                      : ((m_reg[1] > m_reg[2]) ? m_reg[1] : m_reg[2]);
    assign vtx_we = q_valid && q_ready && (q_cmd.op == OP_ADD_VERTEX)
                 && (q_cmd.status == ST_OK);

    function automatic logic signed [31:0] sat32(input logic signed [57:0] x);
        if (x > 58'sd2147483647) return 32'sh7fffffff;
        if (x < -58'sd2147483648) return 32'sh80000000;
        return x[31:0];
    endfunction

    // floor division by 2^14 is an arithmetic shift.
    function automatic logic signed [49:0] fshr(input logic signed [49:0] x);
        return x >>> 14;
    endfunction

    always_comb begin
        unique case (k_reg)
            2'd0:    ra = cmd_reg.ia;
            2'd1:    ra = cmd_reg.ib;
            default: ra = cmd_reg.ic;
        endcase
    end

    // Store writes: a vertex load is written when its command is taken.
    always_ff @(posedge aclk) begin
        if (vtx_we) begin
            pos_mem[q_cmd.ia] <= q_cmd.pos;
            tex_mem[q_cmd.ia] <= q_cmd.tex;
            nrm_mem[q_cmd.ia] <= q_cmd.nrm;
        end
        pos_q <= pos_mem[ra];
        tex_q <= tex_mem[ra];
        nrm_q <= nrm_mem[ra];
    end

    // Accumulator memory: a new vertex zeroes its row, so rows left over from
    // before a clear or reset are never read.
    always_ff @(posedge aclk) begin
        if (acc_we) acc_mem[acc_wa] <= acc_wd;
        acc_q <= acc_mem[ra];
    end

    assign dtrial = {dr_reg, dn_reg[55]} - {2'b0, dd_reg};
    assign prod   = dot_reg * nv_reg[k_reg];
    assign busy_ok = 1'b1;
    assign sum_next = 64'(m_reg[k_reg] * m_reg[k_reg])
                    + ((k_reg == 2'd0) ? 64'd0 : sum_reg);

    always_comb begin
        acc_we = 1'b0;
        acc_wa = ra;
        acc_wd = '0;
        if (vtx_we) begin
            acc_we = 1'b1;
            acc_wa = q_cmd.ia;
        end else if (st_reg == S_WR) begin
            acc_we = 1'b1;
            acc_wd = {sat32(58'(tv_reg[0]) + 58'(tan_reg[0])),
                      sat32(58'(tv_reg[1]) + 58'(tan_reg[1])),
                      sat32(58'(tv_reg[2]) + 58'(tan_reg[2]))};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg     <= S_IDLE;
            ov_reg     <= 1'b0;
        end else begin
            if (m_valid && m_ready) ov_reg <= 1'b0;
            unique case (st_reg)
                S_IDLE: if (q_valid && q_ready) begin
                    cmd_reg <= q_cmd;
                    k_reg   <= 2'd0;
                    od_reg  <= '{tan_x: '0, tan_y: '0, tan_z: '0, status: q_cmd.status};
                    if (q_cmd.op == OP_CLEAR) begin
                        st_reg <= S_CLR;
                    end else if (q_cmd.status != ST_OK) begin
                        ov_reg <= 1'b1;
                    end else if (q_cmd.op == OP_ADD_VERTEX) begin
                        ov_reg <= 1'b1;
                    end else begin
                        st_reg <= S_RD;
                    end
                end
                S_CLR: begin
                    ov_reg     <= 1'b1;
                    st_reg     <= S_IDLE;
                end
                S_RD: st_reg <= S_LD;
                S_LD: begin
                    // Registered store data for vertex k is now valid.
                    p_reg[k_reg][0] <= pos_q[47:32];
                    p_reg[k_reg][1] <= pos_q[31:16];
                    p_reg[k_reg][2] <= pos_q[15:0];
                    t_reg[k_reg][0] <= tex_q[31:16];
                    t_reg[k_reg][1] <= tex_q[15:0];
                    tv_reg[0] <= acc_q[95:64];
                    tv_reg[1] <= acc_q[63:32];
                    tv_reg[2] <= acc_q[31:0];
                    nv_reg[0] <= nrm_q[47:32];
                    nv_reg[1] <= nrm_q[31:16];
                    nv_reg[2] <= nrm_q[15:0];
                    if (cmd_reg.op == OP_READ) begin
                        st_reg <= S_DOT;
                    end else if (k_reg == 2'd2) begin
                        st_reg <= S_DIFF;
                    end else begin
                        k_reg  <= k_reg + 1'b1;
                        st_reg <= S_RD;
                    end
                end
                S_DIFF: begin
                    for (int i = 0; i < 3; i++) begin
                        e1_reg[i] <= 18'(p_reg[1][i]) - 18'(p_reg[0][i]);
                        e2_reg[i] <= 18'(p_reg[2][i]) - 18'(p_reg[0][i]);
                    end
                    d1u_reg <= 17'(t_reg[1][0]) - 17'(t_reg[0][0]);
                    d1v_reg <= 17'(t_reg[1][1]) - 17'(t_reg[0][1]);
                    d2u_reg <= 17'(t_reg[2][0]) - 17'(t_reg[0][0]);
                    d2v_reg <= 17'(t_reg[2][1]) - 17'(t_reg[0][1]);
                    st_reg  <= S_DET;
                end
                S_DET: begin
                    det_reg <= 35'(d1u_reg * d2v_reg) - 35'(d2u_reg * d1v_reg);
                    st_reg  <= S_NUM;
                end
                S_NUM: begin
                    if (det_reg == '0) begin
                        od_reg.status <= ST_DEGENERATE;
                        ov_reg <= 1'b1;
                        st_reg <= S_IDLE;
                    end else begin
                        for (int i = 0; i < 3; i++)
                            num_reg[i] <= 36'(d2v_reg * e1_reg[i]) - 36'(d1v_reg * e2_reg[i]);
                        k_reg  <= 2'd0;
                        dc_reg <= '0;
                        st_reg <= S_DIV;
                    end
                end
                S_DIV: begin
                    // One quotient bit per cycle, one component after another.
                    if (dc_reg == '0) begin
                        dn_reg   <= {num_reg[k_reg][35] ? 36'(-num_reg[k_reg])
                                                        : num_reg[k_reg], 20'd0};
                        dd_reg   <= det_reg[34] ? 36'(-det_reg) : 36'(det_reg);
                        dneg_reg <= num_reg[k_reg][35] ^ det_reg[34];
                        dr_reg   <= '0;
                        dq_reg   <= '0;
                        dc_reg   <= 6'd1;
                    end else if (dc_reg <= 6'd56) begin
                        if (!dtrial[37]) dr_reg <= dtrial[36:0];
                        else dr_reg <= {dr_reg[35:0], dn_reg[55]};
                        dq_reg <= {dq_reg[54:0], !dtrial[37]};
                        dn_reg <= {dn_reg[54:0], 1'b0};
                        dc_reg <= dc_reg + 1'b1;
                    end else begin
                        tan_reg[k_reg] <= sat32(dneg_reg ? -58'(dq_reg) : 58'(dq_reg));
                        dc_reg <= '0;
                        if (k_reg == 2'd2) begin
                            k_reg  <= 2'd0;
                            st_reg <= S_ACC;
                        end else begin
                            k_reg <= k_reg + 1'b1;
                        end
                    end
                end
                S_ACC: st_reg <= S_SUB;
                S_SUB: begin
                    // Read-modify-write of vertex k's accumulators.
                    tv_reg[0] <= acc_q[95:64];
                    tv_reg[1] <= acc_q[63:32];
                    tv_reg[2] <= acc_q[31:0];
                    st_reg <= S_WR;
                end
                S_WR: begin
                    if (k_reg == 2'd2) begin
                        ov_reg <= 1'b1;
                        st_reg <= S_IDLE;
                    end else begin
                        k_reg  <= k_reg + 1'b1;
                        st_reg <= S_ACC;
                    end
                end
                S_DOT: begin
                    dot_reg <= fshr(50'(tv_reg[0] * nv_reg[0]) + 50'(tv_reg[1] * nv_reg[1])
                                   + 50'(tv_reg[2] * nv_reg[2]));
                    k_reg  <= 2'd0;
                    st_reg <= S_DOT2;
                end
                S_DOT2: begin
                    tw_reg[k_reg] <= 34'(tv_reg[k_reg]) - 34'(fshr(prod));
                    if (k_reg == 2'd2) st_reg <= S_NORM;
                    else k_reg <= k_reg + 1'b1;
                end
                S_NORM: begin
                    for (int i = 0; i < 3; i++)
                        m_reg[i] <= tw_reg[i][33] ? 34'(-tw_reg[i]) : 34'(tw_reg[i]);
                    st_reg <= S_SQ;
                    k_reg  <= 2'd0;
                end
                S_SQ: begin
                    // Normalise one bit a cycle so the peak lies in [2^29, 2^30).
                    if (mx == '0) begin
                        od_reg.status <= ST_ZERO;
                        ov_reg <= 1'b1;
                        st_reg <= S_IDLE;
                    end else if (mx >= 34'(1) << 30) begin
                        for (int i = 0; i < 3; i++) m_reg[i] <= m_reg[i] >> 1;
                    end else if (mx < 34'(1) << 29) begin
                        for (int i = 0; i < 3; i++) m_reg[i] <= m_reg[i] << 1;
                    end else begin
                        sum_reg <= sum_next;
                        if (k_reg == 2'd2) begin
                            sq_n_reg <= sum_next;
                            sq_b_reg <= 64'd1 << 62;
                            sq_r_reg <= '0;
                            st_reg   <= S_SQRT;
                        end else begin
                            k_reg <= k_reg + 1'b1;
                        end
                    end
                end
                S_SQRT: begin
                    // Digit-by-digit square root, one result bit per cycle.
                    if (sq_b_reg == '0) begin
                        len_reg <= sq_r_reg[31:0];
                        k_reg   <= 2'd0;
                        dc_reg  <= '0;
                        st_reg  <= S_QDIV;
                    end else begin
                        if (sq_n_reg >= sq_r_reg + sq_b_reg) begin
                            sq_n_reg <= sq_n_reg - (sq_r_reg + sq_b_reg);
                            sq_r_reg <= (sq_r_reg >> 1) + sq_b_reg;
                        end else begin
                            sq_r_reg <= sq_r_reg >> 1;
                        end
                        sq_b_reg <= sq_b_reg >> 2;
                    end
                end
                S_QDIV: begin
                    // Reuse the divider: (m*16384) / len.
                    if (dc_reg == '0) begin
                        dn_reg   <= {m_reg[k_reg], 22'd0} >> 8;
                        dd_reg   <= 36'(len_reg);
                        dneg_reg <= tw_reg[k_reg][33];
                        dr_reg   <= '0;
                        dq_reg   <= '0;
                        dc_reg   <= 6'd1;
                    end else if (dc_reg <= 6'd56) begin
                        if (!dtrial[37]) dr_reg <= dtrial[36:0];
                        else dr_reg <= {dr_reg[35:0], dn_reg[55]};
                        dq_reg <= {dq_reg[54:0], !dtrial[37]};
                        dn_reg <= {dn_reg[54:0], 1'b0};
                        dc_reg <= dc_reg + 1'b1;
                    end else begin
                        o_reg[k_reg] <= dneg_reg ? -16'(dq_reg) : 16'(dq_reg);
                        dc_reg <= '0;
                        if (k_reg == 2'd2) st_reg <= S_OUT;
                        else k_reg <= k_reg + 1'b1;
                    end
                end
                S_OUT: begin
                    od_reg <= '{tan_x: o_reg[0], tan_y: o_reg[1], tan_z: o_reg[2],
                                status: ST_OK};
                    ov_reg <= busy_ok;
                    st_reg <= S_IDLE;
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTH
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg != S_IDLE) |-> !q_ready) else $error("accepted while busy");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid) else $error("result dropped");
    a_ok_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status != ST_OK) |-> (m_data.tan_x == '0))
        else $error("flagged result carries tangent");
`endif
endmodule

[rtl/core/mesh_tangent_generator.sv]
// Channel | Ports                     | Word
// input   | s_valid s_ready s_data    | mtg_in_t: operation, vertex and indices
// result  | m_valid m_ready m_data    | mtg_out_t: tangent and status
// Vertex loads, clears and failed checks finish without the divider; a triangle
// runs the bit-serial divider once per component, and a read normalises by
// shifting, takes a square root and runs three divides.
// Reset is synchronous, active low, and zeroes the vertex count, so no stored
// entry can be reached until it is loaded again.
// The front end and back end each stall on their own through a two-word queue;
// the back end takes no new word while its result waits.
module mesh_tangent_generator (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  mtg_pkg::mtg_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output mtg_pkg::mtg_out_t m_data
);
    import mtg_pkg::*;

    mtg_cmd_t   fq_cmd, qb_cmd;
    logic       fq_valid, fq_ready, qb_valid, qb_ready;

    // Front end: counts vertices and checks indices.
    mtg_front u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data,
        .q_valid(fq_valid), .q_ready(fq_ready), .q_cmd(fq_cmd)
    );

    // Command queue.
    mtg_queue u_queue (
        .aclk, .aresetn,
        .i_valid(fq_valid), .i_ready(fq_ready), .i_cmd(fq_cmd),
        .o_valid(qb_valid), .o_ready(qb_ready), .o_cmd(qb_cmd)
    );

    // Back end: stores, accumulation and normalisation.
    mtg_back u_back (
        .aclk, .aresetn,
        .q_valid(qb_valid), .q_ready(qb_ready), .q_cmd(qb_cmd),
        .m_valid, .m_ready, .m_data
    );

endmodule

[sim/testbench.sv]
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import mtg_pkg::*;

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    mtg_in_t  s_data;
    logic     m_valid;
    logic     m_ready;
    mtg_out_t m_data;

    mesh_tangent_generator DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Shadow of the block's stores, kept in step with every accepted word.
    shortint  shadow_pos[MaxVerts][3];
    shortint  shadow_tex[MaxVerts][2];
    shortint  shadow_nrm[MaxVerts][3];
    int       shadow_acc[MaxVerts][3];
    int       shadow_count;

    mtg_out_t pending_tangents[$];
    int       error_count;
    int       words_sent;
    int       results_seen;
    int       status_seen[5];

    // Directed stimulus: a word and, where obvious, the result typed in.
    typedef struct {
        mtg_in_t  word;
        bit       typed;
        mtg_out_t result;
    } directed_row_t;

    directed_row_t directed_rows[$];

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #30ms;
        $display("Timeout at %0t", $time);
        $display("DONE: errors detected");
        $finish;
    end

    function automatic int clamp32(longint x);
        if (x > 64'sd2147483647) begin
            return 32'sh7fffffff;
        end
        if (x < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return int'(x);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) begin
            bitv = bitv >> 2;
        end
        while (bitv != 0) begin
            if (n >= root + bitv) begin
                n    = n - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // Accumulate one triangle's tangent into its three corners.
    function automatic mtg_out_t add_triangle(int a, int b, int c);
        mtg_out_t res;
        longint   e1[3];
        longint   e2[3];
        longint   d1u, d1v, d2u, d2v, det, num;
        int       tng[3];
        int       corner[3];
        res = '0;
        if (a >= shadow_count || b >= shadow_count || c >= shadow_count) begin
            res.status = ST_RANGE;
            return res;
        end
        for (int k = 0; k < 3; k++) begin
            e1[k] = longint'(shadow_pos[b][k]) - shadow_pos[a][k];
            e2[k] = longint'(shadow_pos[c][k]) - shadow_pos[a][k];
        end
        d1u = longint'(shadow_tex[b][0]) - shadow_tex[a][0];
        d1v = longint'(shadow_tex[b][1]) - shadow_tex[a][1];
        d2u = longint'(shadow_tex[c][0]) - shadow_tex[a][0];
        d2v = longint'(shadow_tex[c][1]) - shadow_tex[a][1];
        det = d1u * d2v - d2u * d1v;
        if (det == 0) begin
            res.status = ST_DEGENERATE;
            return res;
        end
        for (int k = 0; k < 3; k++) begin
            num    = d2v * e1[k] - d1v * e2[k];
            tng[k] = clamp32((num * 1048576) / det);
        end
        corner = '{a, b, c};
        foreach (corner[j]) begin
            for (int k = 0; k < 3; k++) begin
                shadow_acc[corner[j]][k] =
                    clamp32(longint'(shadow_acc[corner[j]][k]) + tng[k]);
            end
        end
        res.status = ST_OK;
        return res;
    endfunction

    // Orthogonalise a vertex's sum against its normal and scale to unit length.
    function automatic mtg_out_t read_tangent(int v);
        mtg_out_t        res;
        longint          tv[3];
        longint          nv[3];
        longint          dot;
        longint unsigned mag[3];
        longint unsigned peak, len, q;
        logic [15:0]     comp[3];
        res = '0;
        if (v >= shadow_count) begin
            res.status = ST_RANGE;
            return res;
        end
        for (int k = 0; k < 3; k++) begin
            tv[k] = shadow_acc[v][k];
            nv[k] = shadow_nrm[v][k];
        end
        dot = (tv[0] * nv[0] + tv[1] * nv[1] + tv[2] * nv[2]) >>> 14;
        for (int k = 0; k < 3; k++) begin
            tv[k]  = tv[k] - ((dot * nv[k]) >>> 14);
            mag[k] = tv[k] < 0 ? longint'(-tv[k]) : tv[k];
        end
        peak = mag[0];
        if (mag[1] > peak) peak = mag[1];
        if (mag[2] > peak) peak = mag[2];
        if (peak == 0) begin
            res.status = ST_ZERO;
            return res;
        end
        while (peak >= (64'd1 << 30)) begin
            peak = peak >> 1;
            for (int k = 0; k < 3; k++) mag[k] = mag[k] >> 1;
        end
        while (peak < (64'd1 << 29)) begin
            peak = peak << 1;
            for (int k = 0; k < 3; k++) mag[k] = mag[k] << 1;
        end
        len = int_sqrt(mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2]);
        for (int k = 0; k < 3; k++) begin
            q       = (mag[k] * 16384) / len;
            comp[k] = tv[k] < 0 ? 16'(-q) : 16'(q);
        end
        res.tan_x  = comp[0];
        res.tan_y  = comp[1];
        res.tan_z  = comp[2];
        res.status = ST_OK;
        return res;
    endfunction

    function automatic mtg_out_t predict_word(mtg_in_t w);
        mtg_out_t res;
        res = '0;
        case (w.operation)
            OP_ADD_VERTEX: begin
                if (shadow_count >= MaxVerts) begin
                    res.status = ST_FULL;
                end else begin
                    shadow_pos[shadow_count] = '{w.pos_x, w.pos_y, w.pos_z};
                    shadow_tex[shadow_count] = '{w.tex_u, w.tex_v};
                    shadow_nrm[shadow_count] = '{w.nrm_x, w.nrm_y, w.nrm_z};
                    shadow_acc[shadow_count] = '{0, 0, 0};
                    shadow_count++;
                end
            end
            OP_ADD_TRI: res = add_triangle(w.idx0, w.idx1, w.idx2);
            OP_READ:    res = read_tangent(w.idx0);
            default: begin
                shadow_count = 0;
                foreach (shadow_acc[i]) shadow_acc[i] = '{0, 0, 0};
            end
        endcase
        return res;
    endfunction

    function automatic mtg_in_t vertex_word(int px, int py, int pz, int u, int v,
                                            int nx, int ny, int nz);
        mtg_in_t w;
        w           = '0;
        w.operation = OP_ADD_VERTEX;
        w.pos_x     = 16'(px);
        w.pos_y     = 16'(py);
        w.pos_z     = 16'(pz);
        w.tex_u     = 16'(u);
        w.tex_v     = 16'(v);
        w.nrm_x     = 16'(nx);
        w.nrm_y     = 16'(ny);
        w.nrm_z     = 16'(nz);
        return w;
    endfunction

    function automatic mtg_in_t index_word(logic [1:0] op, int a, int b, int c);
        mtg_in_t w;
        w           = '0;
        w.operation = op;
        w.idx0      = 10'(a);
        w.idx1      = 10'(b);
        w.idx2      = 10'(c);
        return w;
    endfunction

    function automatic mtg_in_t random_vertex();
        return vertex_word($urandom, $urandom, $urandom, $urandom, $urandom,
                           $urandom_range(0, 32768) - 16384,
                           $urandom_range(0, 32768) - 16384,
                           $urandom_range(0, 32768) - 16384);
    endfunction

    // An index that is mostly within the loaded vertices.
    function automatic int pick_index();
        if (shadow_count > 0 && $urandom_range(0, 9) != 0) begin
            return $urandom_range(0, shadow_count - 1);
        end
        return $urandom_range(0, MaxVerts - 1);
    endfunction

    function automatic mtg_out_t status_only(logic [2:0] st);
        mtg_out_t res;
        res        = '0;
        res.status = st;
        return res;
    endfunction

    // Offer one word, wait for it to be taken, then record its result.
    task automatic send_word(mtg_in_t w, bit typed, mtg_out_t typed_result);
        int       gap;
        mtg_out_t predicted;
        if ((words_sent % 200) < 40) begin
            gap = 0;
        end else begin
            gap = $urandom_range(0, 19);
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        predicted = predict_word(w);
        if (typed) predicted = typed_result;
        pending_tangents = {pending_tangents, predicted};
        words_sent++;
    endtask

    task automatic wait_for_drain();
        s_valid <= 1'b0;
        while (pending_tangents.size() != 0) @(posedge aclk);
    endtask

    // Result side: random stalls, one long hold-off, field-by-field checks.
    initial begin
        int       stall;
        mtg_out_t want;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            if (results_seen == 300) begin
                stall = 2000;
            end else if ((results_seen % 150) < 30) begin
                stall = 0;
            end else begin
                stall = $urandom_range(0, 19);
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            results_seen++;
            if (pending_tangents.size() == 0) begin
                $display("%0t: unexpected result word %p", $time, m_data);
                error_count++;
            end else begin
                want = pending_tangents.pop_front();
                if (m_data.status < 5) status_seen[m_data.status]++;
                if (m_data.tan_x !== want.tan_x || m_data.tan_y !== want.tan_y ||
                    m_data.tan_z !== want.tan_z || m_data.status !== want.status) begin
                    $display("%0t: mismatch, expected %p, actual %p",
                             $time, want, m_data);
                    error_count++;
                end
            end
        end
    end

    // Stimulus.
    initial begin
        mtg_in_t  w;
        int       roll;
        s_valid       = 1'b0;
        s_data        = '0;
        aresetn       = 1'b0;
        error_count   = 0;
        words_sent    = 0;
        results_seen  = 0;
        shadow_count  = 0;
        foreach (status_seen[i]) status_seen[i] = 0;
        foreach (shadow_acc[i]) shadow_acc[i] = '{0, 0, 0};
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part: empty store, extremes, degenerate, saturation, clear.
        directed_rows = '{
            '{index_word(OP_READ, 0, 0, 0), 1, status_only(ST_RANGE)},
            '{index_word(OP_ADD_TRI, 0, 0, 0), 1, status_only(ST_RANGE)},
            '{vertex_word(32767, 32767, 32767, 0, 0, 16384, 0, 0), 1, status_only(ST_OK)},
            '{vertex_word(-32768, -32768, -32768, 4096, 0, 0, 16384, 0), 0, '0},
            '{vertex_word(0, 0, 0, 0, 4096, 0, 0, -16384), 0, '0},
            '{index_word(OP_READ, 0, 0, 0), 1, status_only(ST_ZERO)},
            '{index_word(OP_ADD_TRI, 0, 1, 2), 0, '0},
            '{index_word(OP_READ, 0, 0, 0), 0, '0},
            '{index_word(OP_READ, 1, 0, 0), 0, '0},
            '{index_word(OP_READ, 2, 0, 0), 0, '0},
            '{index_word(OP_ADD_TRI, 0, 0, 1), 1, status_only(ST_DEGENERATE)},
            '{index_word(OP_ADD_TRI, 0, 1, 3), 1, status_only(ST_RANGE)},
            '{vertex_word(100, 0, 0, 32767, -32768, -16384, 0, 0), 0, '0},
            '{vertex_word(0, -200, 50, -32768, 32767, 0, -16384, 0), 0, '0},
            '{index_word(OP_ADD_TRI, 3, 4, 0), 0, '0},
            '{vertex_word(-32768, 32767, -32768, 1, 0, 11585, 11585, 0), 0, '0},
            '{vertex_word(32767, -32768, 32767, 0, 1, 0, 0, 16384), 0, '0},
            '{index_word(OP_ADD_TRI, 2, 5, 6), 0, '0},
            '{index_word(OP_ADD_TRI, 2, 5, 6), 0, '0},
            '{index_word(OP_READ, 5, 0, 0), 0, '0},
            '{index_word(OP_READ, 3, 0, 0), 0, '0},
            '{index_word(OP_ADD_TRI, 1023, 1023, 1023), 1, status_only(ST_RANGE)},
            '{index_word(OP_CLEAR, 1023, 1023, 1023), 1, status_only(ST_OK)},
            '{index_word(OP_READ, 0, 0, 0), 1, status_only(ST_RANGE)}
        };
        foreach (directed_rows[i]) begin
            send_word(directed_rows[i].word, directed_rows[i].typed,
                      directed_rows[i].result);
        end
        wait_for_drain();

        // Random part: mostly loaded vertices, valid triangles and reads, some noise.
        for (int n = 0; n < 300; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 30 || shadow_count < 3) begin
                w = random_vertex();
                if ($urandom_range(0, 7) == 0 && shadow_count > 0) begin
                    w.tex_u = shadow_tex[shadow_count - 1][0];
                    w.tex_v = shadow_tex[shadow_count - 1][1];
                end
            end else if (roll < 65) begin
                w = index_word(OP_ADD_TRI, pick_index(), pick_index(), pick_index());
            end else if (roll < 98) begin
                w = index_word(OP_READ, pick_index(), $urandom, $urandom);
            end else begin
                w = index_word(OP_CLEAR, $urandom, $urandom, $urandom);
            end
            if ($urandom_range(0, 3) == 0 && w.operation != OP_ADD_VERTEX) begin
                w.pos_x = $urandom;
                w.nrm_z = $urandom;
            end
            send_word(w, 0, '0);
            if (n == 150) wait_for_drain();
        end

        // Fill the store to its limit, then work at the top indices.
        send_word(index_word(OP_CLEAR, 0, 0, 0), 0, '0);
        while (shadow_count < MaxVerts) begin
            send_word(random_vertex(), 0, '0);
            if (shadow_count % 97 == 0) begin
                send_word(index_word(OP_ADD_TRI, shadow_count - 1, shadow_count - 2,
                                     shadow_count - 3), 0, '0);
            end
        end
        repeat (3) send_word(random_vertex(), 0, '0);
        for (int n = 0; n < 60; n++) begin
            if (n % 2 == 0) begin
                w = index_word(OP_ADD_TRI, $urandom_range(1000, 1023),
                               $urandom_range(0, 1023), 1023);
            end else begin
                w = index_word(OP_READ, $urandom_range(1000, 1023), 0, 0);
            end
            send_word(w, 0, '0);
        end
        wait_for_drain();

        repeat (300) @(posedge aclk);
        $display("Covered %0d words: %0d ok, %0d degenerate, %0d out of range,",
                 words_sent, status_seen[0], status_seen[1], status_seen[2]);
        $display("%0d store full and %0d zero tangent results.",
                 status_seen[3], status_seen[4]);
        if (error_count == 0 && pending_tangents.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

`default_nettype wire

[mesh_tangent_generator.f]
rtl/core/mtg_pkg.sv
rtl/core/mtg_front.sv
rtl/core/mtg_queue.sv
rtl/core/mtg_back.sv
rtl/core/mesh_tangent_generator.sv
sim/testbench.sv
